// ===== rtl/slu_pkg.sv =====
// Package: item types, decoder modes and character constants for the string literal unescaper.
package slu_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       has_char;
    logic       end_mark;
    logic [1:0] error_code;
  } out_item_t;

  typedef enum logic [2:0] {
    MODE_START = 3'd0,
    MODE_BODY  = 3'd1,
    MODE_ESC   = 3'd2,
    MODE_DEC1  = 3'd3,
    MODE_DEC2  = 3'd4,
    MODE_DRAIN = 3'd5
  } mode_t;

  typedef struct packed {
    mode_t      mode;
    logic [9:0] acc;
    logic       ended;
  } slu_state_t;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_RANGE  = 2'd1;
  localparam logic [1:0] ERR_LETTER = 2'd2;

  localparam logic [9:0] DEC_LIMIT = 10'd127;
  localparam logic [9:0] ACC_MAX   = 10'd999;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_V      = 8'h76;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_E      = 8'h65;
  localparam logic [7:0] CODE_LF   = 8'h0A;
  localparam logic [7:0] CODE_CR   = 8'h0D;
  localparam logic [7:0] CODE_TAB  = 8'h09;
  localparam logic [7:0] CODE_FF   = 8'h0C;
  localparam logic [7:0] CODE_VT   = 8'h0B;
  localparam logic [7:0] CODE_BEL  = 8'h07;
  localparam logic [7:0] CODE_ESC  = 8'h1B;

endpackage

// ===== rtl/string_literal_unescaper.sv =====
// Top level: input register, byte decoder and result register of the string literal unescaper.
//
//   channel | direction | handshake          | payload
//   in      | to block  | in_valid, in_stall  | in_item  (in_byte, is_last)
//   out     | from block| out_valid, out_stall| out_item (out_char, has_char, end_mark, error_code)
//
// Each byte is taken into the input register and, unless the result register is held, is decoded
// into the result register; its result is offered from there when the decode produces one.
// One byte is taken every cycle while in_stall is low; the decode step holds the whole state update.
// A stall on out holds the result register; a byte waiting in the input register is held
// and in_stall rises.
// Reset is synchronous and clears the decoder state and both valid flags.
module string_literal_unescaper (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  slu_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output slu_pkg::out_item_t out_item
);

  logic                in_reg_valid;
  slu_pkg::in_item_t   in_reg;
  slu_pkg::slu_state_t state;
  slu_pkg::slu_state_t state_next;
  logic                produce;
  slu_pkg::out_item_t  result;
  logic                hold;
  logic                consume;

  assign hold     = out_valid && out_stall;
  assign consume  = in_reg_valid && !hold;
  assign in_stall = in_reg_valid && hold;

  slu_decode u_decode (
    .state      (state),
    .item       (in_reg),
    .state_next (state_next),
    .produce    (produce),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
      out_valid    <= 1'b0;
      state.mode   <= slu_pkg::MODE_START;
      state.acc    <= '0;
      state.ended  <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        in_reg_valid <= 1'b1;
      end else if (consume) begin
        in_reg_valid <= 1'b0;
      end
      if (consume) begin
        state     <= state_next;
        out_valid <= produce;
      end else if (!hold) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_reg <= in_item;
    end
    if (consume && produce) begin
      out_item <= result;
    end
  end

  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    consume && in_reg.is_last |=> state.mode == slu_pkg::MODE_START)
    else $error("decoder did not return to start after the closing byte");

  a_last_gives_end: assert property (@(posedge clk) disable iff (rst)
    consume && in_reg.is_last |=> out_valid && out_item.end_mark)
    else $error("closing byte gave no end marker");

  a_char_no_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.has_char |-> out_item.error_code == slu_pkg::ERR_NONE)
    else $error("result carries both a character and an error");

  a_acc_bound: assert property (@(posedge clk) disable iff (rst)
    state.acc <= slu_pkg::ACC_MAX)
    else $error("digit accumulator out of range");

endmodule

// ===== rtl/slu_decode.sv =====
// Combinational decoder: next state and result for one byte of a literal.
module slu_decode (
  input  slu_pkg::slu_state_t state,
  input  slu_pkg::in_item_t   item,
  output slu_pkg::slu_state_t state_next,
  output logic                produce,
  output slu_pkg::out_item_t  result
);

  logic       is_digit;
  logic [3:0] digit_val;
  logic [9:0] acc_taken;
  logic       ended_taken;
  logic [9:0] acc_final;
  logic       letter_ok;
  logic [7:0] letter_code;

  assign is_digit  = (item.in_byte >= slu_pkg::CH_ZERO) && (item.in_byte <= slu_pkg::CH_NINE);
  assign digit_val = 4'(item.in_byte - slu_pkg::CH_ZERO);

  always_comb begin
    if (!state.ended && is_digit) begin
      acc_taken   = 10'(state.acc * 10'd10) + 10'(digit_val);
      ended_taken = state.ended;
    end else begin
      acc_taken   = state.acc;
      ended_taken = 1'b1;
    end
  end

  always_comb begin
    letter_ok   = 1'b1;
    letter_code = '0;
    unique case (item.in_byte)
      slu_pkg::CH_N: letter_code = slu_pkg::CODE_LF;
      slu_pkg::CH_R: letter_code = slu_pkg::CODE_CR;
      slu_pkg::CH_T: letter_code = slu_pkg::CODE_TAB;
      slu_pkg::CH_F: letter_code = slu_pkg::CODE_FF;
      slu_pkg::CH_V: letter_code = slu_pkg::CODE_VT;
      slu_pkg::CH_A: letter_code = slu_pkg::CODE_BEL;
      slu_pkg::CH_E: letter_code = slu_pkg::CODE_ESC;
      default:       letter_ok   = 1'b0;
    endcase
  end

  // The closing byte finishes an open decimal escape with the digits seen so far.
  assign acc_final = item.is_last ? state.acc : acc_taken;

  always_comb begin
    state_next = state;
    produce    = 1'b0;
    result     = '0;
    if (item.is_last) begin
      state_next.mode  = slu_pkg::MODE_START;
      state_next.acc   = '0;
      state_next.ended = 1'b0;
      produce          = 1'b1;
      result.end_mark  = 1'b1;
      unique case (state.mode)
        slu_pkg::MODE_DEC1, slu_pkg::MODE_DEC2: begin
          if (acc_final > slu_pkg::DEC_LIMIT) begin
            result.error_code = slu_pkg::ERR_RANGE;
          end else begin
            result.out_char = acc_final[7:0];
            result.has_char = 1'b1;
          end
        end
        slu_pkg::MODE_ESC: result.error_code = slu_pkg::ERR_LETTER;
        default:           result.error_code = slu_pkg::ERR_NONE;
      endcase
    end else begin
      unique case (state.mode)
        slu_pkg::MODE_BODY: begin
          if (item.in_byte == slu_pkg::CH_BSLASH) begin
            state_next.mode = slu_pkg::MODE_ESC;
          end else begin
            produce         = 1'b1;
            result.out_char = item.in_byte;
            result.has_char = 1'b1;
          end
        end
        slu_pkg::MODE_ESC: begin
          if (is_digit) begin
            state_next.acc   = 10'(digit_val);
            state_next.ended = 1'b0;
            state_next.mode  = slu_pkg::MODE_DEC1;
          end else if (letter_ok) begin
            produce         = 1'b1;
            result.out_char = letter_code;
            result.has_char = 1'b1;
            state_next.mode = slu_pkg::MODE_BODY;
          end else begin
            produce           = 1'b1;
            result.error_code = slu_pkg::ERR_LETTER;
            state_next.mode   = slu_pkg::MODE_DRAIN;
          end
        end
        slu_pkg::MODE_DEC1: begin
          state_next.acc   = acc_taken;
          state_next.ended = ended_taken;
          state_next.mode  = slu_pkg::MODE_DEC2;
        end
        slu_pkg::MODE_DEC2: begin
          produce          = 1'b1;
          state_next.acc   = '0;
          state_next.ended = 1'b0;
          if (acc_taken > slu_pkg::DEC_LIMIT) begin
            result.error_code = slu_pkg::ERR_RANGE;
            state_next.mode   = slu_pkg::MODE_DRAIN;
          end else begin
            result.out_char = acc_taken[7:0];
            result.has_char = 1'b1;
            state_next.mode = slu_pkg::MODE_BODY;
          end
        end
        slu_pkg::MODE_DRAIN: state_next.mode = slu_pkg::MODE_DRAIN;
        default:             state_next.mode = slu_pkg::MODE_BODY;
      endcase
    end
  end

endmodule
